// ===== rtl/ipdpf_pkg.sv =====
// shared types and constants for the destination port allow filter
package ipdpf_pkg;

   localparam int TableEntries = 64;
   localparam int TableIdxW    = (TableEntries > 1) ? $clog2(TableEntries) : 1;

   localparam logic [3:0]  IhlMask     = 4'hF;
   localparam logic [15:0] ProtoOffset = 16'd9;
   localparam logic [15:0] PortOffset  = 16'd2;
   localparam logic [7:0]  ProtoTcp    = 8'd6;
   localparam logic [7:0]  ProtoUdp    = 8'd17;

   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   // work item handed from front to back
   typedef struct packed {
      cmd_type     kind;
      logic        check_port;
      logic [15:0] port;
      logic [15:0] length;
   } job_type;

   // one result item
   typedef struct packed {
      logic        result_kind;
      logic        pass;
      logic [15:0] return_length;
      logic [1:0]  table_status;
      logic [31:0] passed_count;
      logic [31:0] dropped_count;
   } rsp_type;

endpackage

// ===== rtl/ipdpf_front.sv =====
// front: parses packet bytes and turns items into jobs
module ipdpf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_cmd,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic [15:0]       in_port,
   output logic              job_valid,
   input  logic              job_ready,
   output ipdpf_pkg::job_type job
);
   import ipdpf_pkg::*;

   logic [15:0] offset_ff, offset_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  words_ff, words_in;
   logic [15:0] dport_ff, dport_in;
   logic        jvalid_ff, jvalid_in;
   job_type     job_ff, job_in;
   logic        take;
   logic [15:0] hlen;
   logic [7:0]  proto_now;
   logic [3:0]  words_now;
   cmd_type     cmd;

   assign cmd       = cmd_type'(in_cmd);
   assign in_ready  = !jvalid_ff || job_ready;
   assign take      = in_valid && in_ready;
   assign job_valid = jvalid_ff;
   assign job       = job_ff;

   // header field capture
   always_comb begin
      words_now = (offset_ff == 16'd0) ? (in_byte[3:0] & IhlMask) : words_ff;
      proto_now = (offset_ff == ProtoOffset) ? in_byte : proto_ff;
      hlen      = {10'd0, words_now, 2'b00};
      dport_in  = dport_ff;
      if (offset_ff == hlen + PortOffset) dport_in[15:8] = in_byte;
      if (offset_ff == hlen + PortOffset + 16'd1) dport_in[7:0] = in_byte;
      offset_in = offset_ff;
      words_in  = words_ff;
      proto_in  = proto_ff;
      jvalid_in = jvalid_ff && !job_ready;
      job_in    = job_ff;
      if (take) begin
         case (cmd) inside
            CMD_BYTE: begin
               if (in_last) begin
                  jvalid_in         = 1'b1;
                  job_in.kind       = CMD_BYTE;
                  job_in.check_port = (proto_now == ProtoTcp) || (proto_now == ProtoUdp);
                  job_in.port       = dport_in;
                  job_in.length     = (offset_ff == 16'hFFFF) ? 16'hFFFF
                                                              : offset_ff + 16'd1;
                  offset_in = '0;
                  words_in  = '0;
                  proto_in  = '0;
                  dport_in  = '0;
               end else begin
                  if (offset_ff != 16'hFFFF) offset_in = offset_ff + 16'd1;
                  words_in = words_now;
                  proto_in = proto_now;
               end
            end
            CMD_ADD, CMD_REMOVE: begin
               jvalid_in         = 1'b1;
               job_in.kind       = cmd;
               job_in.check_port = 1'b0;
               job_in.port       = in_port;
               job_in.length     = '0;
               dport_in          = dport_ff;
            end
            default: dport_in = dport_ff;
         endcase
      end else begin
         dport_in = dport_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         words_ff  <= '0;
         proto_ff  <= '0;
         dport_ff  <= '0;
         jvalid_ff <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         words_ff  <= words_in;
         proto_ff  <= proto_in;
         dport_ff  <= dport_in;
         jvalid_ff <= jvalid_in;
      end
      job_ff <= job_in;
   end

endmodule

// ===== rtl/ipdpf_back.sv =====
// back: port table lookup, table updates and counters
module ipdpf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  ipdpf_pkg::job_type job,
   output logic               out_valid,
   input  logic               out_ready,
   output ipdpf_pkg::rsp_type out
);
   import ipdpf_pkg::*;

   logic [15:0]          ports_ff [TableEntries];
   logic [15:0]          ports_in [TableEntries];
   logic [TableEntries-1:0] valid_ff, valid_in, hit;
   logic [31:0]          pass_ff, pass_in, drop_ff, drop_in;
   logic                 ovalid_ff, ovalid_in;
   rsp_type              out_ff, out_in;
   logic                 take, found, free_any, ok;
   logic [TableIdxW-1:0] hit_idx, free_idx;

   assign job_ready = !ovalid_ff || out_ready;
   assign take      = job_valid && job_ready;
   assign out_valid = ovalid_ff;
   assign out       = out_ff;

   // parallel match and first free entry
   always_comb begin
      found    = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < TableEntries; i++) begin
         hit[i] = valid_ff[i] && (ports_ff[i] == job.port);
      end
      for (int i = TableEntries - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found   = 1'b1;
            hit_idx = TableIdxW'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = TableIdxW'(i);
         end
      end
   end

   // job execution
   always_comb begin
      ports_in  = ports_ff;
      valid_in  = valid_ff;
      pass_in   = pass_ff;
      drop_in   = drop_ff;
      ovalid_in = ovalid_ff && !out_ready;
      out_in    = out_ff;
      ok        = !job.check_port || found;
      if (take) begin
         ovalid_in = 1'b1;
         out_in    = '0;
         case (job.kind)
            CMD_BYTE: begin
               if (ok) pass_in = pass_ff + 32'd1;
               else    drop_in = drop_ff + 32'd1;
               out_in.pass          = ok;
               out_in.return_length = ok ? job.length : 16'd0;
            end
            CMD_ADD: begin
               out_in.result_kind = 1'b1;
               if (!found) begin
                  if (free_any) begin
                     ports_in[free_idx] = job.port;
                     valid_in[free_idx] = 1'b1;
                  end else begin
                     out_in.table_status = ST_FULL;
                  end
               end
            end
            default: begin
               out_in.result_kind = 1'b1;
               if (found) valid_in[hit_idx] = 1'b0;
               else       out_in.table_status = ST_ABSENT;
            end
         endcase
         out_in.passed_count  = pass_in;
         out_in.dropped_count = drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         pass_ff   <= '0;
         drop_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         pass_ff   <= pass_in;
         drop_ff   <= drop_in;
         ovalid_ff <= ovalid_in;
      end
      ports_ff <= ports_in;
      out_ff   <= out_in;
   end

endmodule

// ===== rtl/ipv4_dest_port_allow_filter.sv =====
// top level of the ipv4 destination port allow filter
// path: from input transfer to result through the front register, then the back register
// throughput: one item per cycle unless stalled; parallel compare over all entries
// non-last bytes give no result and only update parse state; unused command changes nothing
// reset: synchronous, clears parse state, table valid bits, counters and handshakes
// stall: each register stage holds its item while the stage after it is stalled
module ipv4_dest_port_allow_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_byte[7:0], port_value[23:8]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   input  logic        req_tlast,  // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // pass, return_length, table_status,
                                   // passed_count, dropped_count, zero pad
   output logic        rsp_tuser   // result_kind
);
   import ipdpf_pkg::*;

   logic    job_valid, job_ready;
   job_type job;
   rsp_type rsp;

   ipdpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_byte   (req_tdata[7:0]),
      .in_last   (req_tlast),
      .in_port   (req_tdata[23:8]),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   ipdpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out       (rsp)
   );

   assign rsp_tuser = rsp.result_kind;
   assign rsp_tdata = {5'd0, rsp.dropped_count, rsp.passed_count, rsp.table_status,
                       rsp.return_length, rsp.pass};

endmodule
